### rtl/core/mks_pkg.sv
package mks_pkg;

  localparam logic [3:0] NoMatch  = 4'd13;
  localparam logic [2:0] DriveAll = 3'd7;
  localparam logic [2:0] DriveCol0 = 3'd1;
  localparam logic [2:0] DriveCol1 = 3'd2;
  localparam logic [2:0] DriveCol2 = 3'd4;
  localparam logic [15:0] DebounceReset = 16'd30;

  localparam logic [1:0] Col0 = 2'd0;
  localparam logic [1:0] Col1 = 2'd1;
  localparam logic [1:0] Col2 = 2'd2;

  typedef enum logic [5:0] {
    PhIdle     = 6'b000001,
    PhDebounce = 6'b000010,
    PhScan0    = 6'b000100,
    PhScan1    = 6'b001000,
    PhScan2    = 6'b010000,
    PhRelease  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [3:0] rows;
  } row_beat_t;

  typedef struct packed {
    logic [2:0] drive;
    logic       key_valid;
    logic [3:0] code;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] code;
  } decode_t;

  // single-row hit on a driven column, per the fixed key layout
  function automatic decode_t decode_col(logic [1:0] col, logic [3:0] rows);
    decode_t    d;
    logic [1:0] r;
    logic       one;
    d   = '{hit: 1'b0, code: 4'd0};
    one = 1'b1;
    r   = 2'd0;
    case (rows)
      4'b0001: r = 2'd0;
      4'b0010: r = 2'd1;
      4'b0100: r = 2'd2;
      4'b1000: r = 2'd3;
      default: one = 1'b0;
    endcase
    if (one) begin
      d.hit = 1'b1;
      case ({col, r})
        {Col0, 2'd0}: d.code = 4'd0;
        {Col0, 2'd1}: d.code = 4'd7;
        {Col0, 2'd2}: d.code = 4'd4;
        {Col0, 2'd3}: d.code = 4'd1;
        {Col1, 2'd0}: d.hit  = 1'b0;
        {Col1, 2'd1}: d.code = 4'd8;
        {Col1, 2'd2}: d.code = 4'd5;
        {Col1, 2'd3}: d.code = 4'd2;
        {Col2, 2'd0}: d.code = 4'd10;
        {Col2, 2'd1}: d.code = 4'd9;
        {Col2, 2'd2}: d.code = 4'd6;
        {Col2, 2'd3}: d.code = 4'd3;
        default:      d.hit  = 1'b0;
      endcase
    end
    return d;
  endfunction

endpackage

### rtl/core/mks_in_reg.sv
module mks_in_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        row_lines_i,
  input  logic              out_free_i,
  output logic              advance_o,
  output mks_pkg::row_beat_t beat_o
);

  logic       valid_q;
  logic       valid_d;
  logic [3:0] rows_q;

  assign advance_o  = valid_q && out_free_i;
  assign in_ready_o = !valid_q || advance_o;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      rows_q <= row_lines_i;
    end
  end

  assign beat_o = '{valid: valid_q, rows: rows_q};

endmodule

### rtl/core/mks_scan_core.sv
module mks_scan_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [15:0]        cfg_debounce_ticks_i,
  input  logic               advance_i,
  input  mks_pkg::row_beat_t beat_i,
  output mks_pkg::result_t   result_o
);

  mks_pkg::phase_e phase_q, phase_d;
  logic [15:0]     wait_q, wait_d;
  logic [3:0]      held_q, held_d;
  logic [15:0]     debounce_q;
  logic [15:0]     wait_inc;
  mks_pkg::decode_t dec;
  logic [1:0]      scan_col;

  assign wait_inc = wait_q + 16'd1;

  always_comb begin
    unique case (phase_q)
      mks_pkg::PhScan1: scan_col = mks_pkg::Col1;
      mks_pkg::PhScan2: scan_col = mks_pkg::Col2;
      default:          scan_col = mks_pkg::Col0;
    endcase
  end

  assign dec = mks_pkg::decode_col(scan_col, beat_i.rows);

  always_comb begin
    phase_d  = phase_q;
    wait_d   = wait_q;
    held_d   = held_q;
    result_o = '{drive: mks_pkg::DriveAll, key_valid: 1'b0, code: 4'd0};
    unique case (phase_q)
      mks_pkg::PhDebounce: begin
        wait_d = wait_inc;
        // a wrapped count also ends the wait
        if (wait_inc >= debounce_q || wait_inc == 16'd0) begin
          if (beat_i.rows != 4'd0) begin
            held_d         = mks_pkg::NoMatch;
            phase_d        = mks_pkg::PhScan0;
            result_o.drive = mks_pkg::DriveCol0;
          end else begin
            phase_d = mks_pkg::PhIdle;
          end
        end
      end
      mks_pkg::PhScan0: begin
        if (dec.hit) held_d = dec.code;
        phase_d        = mks_pkg::PhScan1;
        result_o.drive = mks_pkg::DriveCol1;
      end
      mks_pkg::PhScan1: begin
        if (dec.hit) held_d = dec.code;
        phase_d        = mks_pkg::PhScan2;
        result_o.drive = mks_pkg::DriveCol2;
      end
      mks_pkg::PhScan2: begin
        if (dec.hit) held_d = dec.code;
        phase_d = mks_pkg::PhRelease;
      end
      mks_pkg::PhRelease: begin
        if (beat_i.rows == 4'd0) begin
          result_o.key_valid = 1'b1;
          result_o.code      = held_q;
          phase_d            = mks_pkg::PhIdle;
        end
      end
      default: begin
        phase_d = mks_pkg::PhIdle;
        if (beat_i.rows != 4'd0) begin
          wait_d  = 16'd0;
          phase_d = mks_pkg::PhDebounce;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mks_pkg::PhIdle;
      wait_q     <= 16'd0;
      held_q     <= mks_pkg::NoMatch;
      debounce_q <= mks_pkg::DebounceReset;
    end else begin
      if (cfg_valid_i) begin
        debounce_q <= cfg_debounce_ticks_i;
      end
      if (advance_i) begin
        phase_q <= phase_d;
        wait_q  <= wait_d;
        held_q  <= held_d;
      end
    end
  end

endmodule

### rtl/core/mks_out_reg.sv
module mks_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             advance_i,
  input  mks_pkg::result_t result_i,
  output logic             out_free_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       column_drive_o,
  output logic             key_valid_o,
  output logic [3:0]       key_code_o
);

  logic             valid_q, valid_d;
  mks_pkg::result_t res_q;

  assign out_free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (advance_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o    = valid_q;
  assign column_drive_o = res_q.drive;
  assign key_valid_o    = res_q.key_valid;
  assign key_code_o     = res_q.code;

endmodule

### rtl/core/matrix_keypad_scanner_unit.sv
// 3x4 keypad scanner: each beat on the input channel is one scan tick carrying the
// sampled row lines, and yields exactly one result beat with the column drive for
// the next tick, a key-valid flag and the key code (0..10, or 13 when no single-row
// hit was seen). One beat is taken every cycle when the output side keeps up; a
// result passes through the input register and then the result register, with
// the scan state updated as the beat moves between them. The debounce length is
// written through the config channel, which is always ready and should be used
// only while no beat is in flight.
module matrix_keypad_scanner_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_debounce_ticks_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  row_lines_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  column_drive_o,
  output logic        key_valid_o,
  output logic [3:0]  key_code_o
);

  logic               advance;
  logic               out_free;
  mks_pkg::row_beat_t beat;
  mks_pkg::result_t   result;

  assign cfg_ready_o = 1'b1;

  mks_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .row_lines_i (row_lines_i),
    .out_free_i  (out_free),
    .advance_o   (advance),
    .beat_o      (beat)
  );

  mks_scan_core u_core (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_debounce_ticks_i (cfg_debounce_ticks_i),
    .advance_i            (advance),
    .beat_i               (beat),
    .result_o             (result)
  );

  mks_out_reg u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .result_i       (result),
    .out_free_o     (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .column_drive_o (column_drive_o),
    .key_valid_o    (key_valid_o),
    .key_code_o     (key_code_o)
  );

endmodule

### rtl/core/mks_checker.sv
module mks_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  column_drive_o,
  input logic        key_valid_o,
  input logic [3:0]  key_code_o
);

  // no code without a key
  a_code_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !key_valid_o) |-> (key_code_o == 4'd0))
    else $error("key code nonzero without key valid");

  // a key is only reported while all columns are driven
  a_valid_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && key_valid_o) |-> (column_drive_o == 3'd7))
    else $error("key reported while scanning a column");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(key_code_o == 4'd11 || key_code_o == 4'd12 ||
                      key_code_o == 4'd14 || key_code_o == 4'd15))
    else $error("key code out of range");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(key_code_o) &&
                                       $stable(column_drive_o)))
    else $error("output beat dropped or changed while stalled");

endmodule

bind matrix_keypad_scanner_unit mks_checker u_mks_checker (.*);
